// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checkers of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define ASSERT_SAME(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled in reset.
`define ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: hw/rtl/tv1d_pkg.sv
// ----------------------------------------------------------------------------
// tv1d_pkg
// Constants, command codes, status type and helpers of the 1-D TV denoiser.
// ----------------------------------------------------------------------------
package tv1d_pkg;

  localparam int MAX_LEN = 64;
  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int SW = 32;
  localparam int LW = 31;
  localparam int VW = 40;
  localparam int DCW = $clog2(VW);
  localparam int GUARD_MAX = 8 * MAX_LEN * MAX_LEN;
  localparam int GW = $clog2(GUARD_MAX + 1) + 1;
  localparam logic [LW-1:0] LAMBDA_RESET = LW'(65536);

  localparam int CMD_W = 5;
  localparam logic [CMD_W-1:0] CMD_NOP     = 5'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD    = 5'd1;
  localparam logic [CMD_W-1:0] CMD_INIT_A  = 5'd2;
  localparam logic [CMD_W-1:0] CMD_INIT_B  = 5'd3;
  localparam logic [CMD_W-1:0] CMD_TOP     = 5'd4;
  localparam logic [CMD_W-1:0] CMD_RD_K0   = 5'd5;
  localparam logic [CMD_W-1:0] CMD_RD_K1   = 5'd6;
  localparam logic [CMD_W-1:0] CMD_B1      = 5'd7;
  localparam logic [CMD_W-1:0] CMD_B3      = 5'd8;
  localparam logic [CMD_W-1:0] CMD_KINC    = 5'd9;
  localparam logic [CMD_W-1:0] CMD_WR_MIN  = 5'd10;
  localparam logic [CMD_W-1:0] CMD_WR_MAX  = 5'd11;
  localparam logic [CMD_W-1:0] CMD_E1      = 5'd12;
  localparam logic [CMD_W-1:0] CMD_E2      = 5'd13;
  localparam logic [CMD_W-1:0] CMD_F1      = 5'd14;
  localparam logic [CMD_W-1:0] CMD_F2      = 5'd15;
  localparam logic [CMD_W-1:0] CMD_DIV_END = 5'd16;
  localparam logic [CMD_W-1:0] CMD_DIV_MIN = 5'd17;
  localparam logic [CMD_W-1:0] CMD_DIV_MAX = 5'd18;
  localparam logic [CMD_W-1:0] CMD_APP_MIN = 5'd19;
  localparam logic [CMD_W-1:0] CMD_APP_MAX = 5'd20;
  localparam logic [CMD_W-1:0] CMD_ORD     = 5'd21;
  localparam logic [CMD_W-1:0] CMD_OLAT    = 5'd22;
  localparam logic [CMD_W-1:0] CMD_ONEXT   = 5'd23;

  typedef struct packed {
    logic fill_last;
    logic umin_neg;
    logic umax_pos;
    logic umin_lt_nl;
    logic umax_gt_l;
    logic umin_ge_l;
    logic umax_le_nl;
    logic k_eq_last;
    logic k_gt_last;
    logic k0_ge_km;
    logic k0_ge_kp;
    logic k0_ge_k;
    logic guard_hit;
    logic div_busy;
    logic o_last;
  } tv1d_stat_t;

  function automatic logic [SW-1:0] sat32(input logic signed [VW-1:0] v);
    if (v > $signed({{(VW-SW+1){1'b0}}, {(SW-1){1'b1}}})) begin
      return {1'b0, {(SW-1){1'b1}}};
    end else if (v < $signed({{(VW-SW+1){1'b1}}, {(SW-1){1'b0}}})) begin
      return {1'b1, {(SW-1){1'b0}}};
    end else begin
      return v[SW-1:0];
    end
  endfunction

endpackage

// File: hw/rtl/tv1d_ram.sv
// ----------------------------------------------------------------------------
// tv1d_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tv1d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/tv1d_div.sv
// ----------------------------------------------------------------------------
// tv1d_div
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module tv1d_div import tv1d_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [VW-1:0] dividend,
  input  logic [CW-1:0]        divisor,
  output logic                 busy,
  output logic signed [VW-1:0] quot
);

  logic [VW-1:0]  mag;
  logic [CW-1:0]  rem;
  logic [CW-1:0]  dvs;
  logic           neg;
  logic [DCW-1:0] cnt;
  logic [CW:0]    rem_sh;
  logic           ge;

  assign rem_sh = {rem, mag[VW-1]};
  assign ge = rem_sh >= {1'b0, dvs};
  assign quot = neg ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      mag  <= dividend[VW-1] ? VW'(-dividend) : dividend;
      neg  <= dividend[VW-1];
      rem  <= '0;
      dvs  <= divisor;
      cnt  <= DCW'(VW - 1);
    end else if (busy) begin
      rem <= ge ? CW'(rem_sh - {1'b0, dvs}) : CW'(rem_sh);
      mag <= {mag[VW-2:0], ge};
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/tv1d_dpath.sv
// ----------------------------------------------------------------------------
// tv1d_dpath
// Datapath: sample and result stores, scan registers, divider and output.
// ----------------------------------------------------------------------------
module tv1d_dpath import tv1d_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [CMD_W-1:0] cmd,
  input  logic [SW-1:0]    s_tdata,
  input  logic             s_tlast,
  input  logic             cfg_valid,
  input  logic [LW-1:0]    cfg_data,
  output tv1d_stat_t       stat,
  output logic [SW-1:0]    m_tdata,
  output logic             m_tlast
);

  logic [LW-1:0]        lam;
  logic [AW-1:0]        fill;
  logic [CW-1:0]        n;
  logic [CW-1:0]        k, k0, km, kp;
  logic [AW-1:0]        oidx;
  logic [GW-1:0]        guard;
  logic signed [VW-1:0] vmin, vmax, umin, umax, smp;
  logic [SW-1:0]        s_rdata, r_rdata;
  logic [AW-1:0]        s_raddr;
  logic signed [VW-1:0] rdx, lamx, two;
  logic [CW-1:0]        len, nm1, kp1;
  logic                 div_start, div_busy;
  logic signed [VW-1:0] div_in, quot;
  logic                 r_we;

  assign rdx  = {{(VW-SW){s_rdata[SW-1]}}, s_rdata};
  assign lamx = {{(VW-LW){1'b0}}, lam};
  assign two  = lamx <<< 1;
  assign len  = k - k0 + 1'b1;
  assign nm1  = n - 1'b1;
  assign kp1  = k + 1'b1;

  always_comb begin
    case (cmd)
      CMD_INIT_A: s_raddr = '0;
      CMD_RD_K1:  s_raddr = kp1[AW-1:0];
      default:    s_raddr = k0[AW-1:0];
    endcase
  end

  assign div_start = (cmd == CMD_DIV_END) || (cmd == CMD_DIV_MIN) || (cmd == CMD_DIV_MAX);

  always_comb begin
    case (cmd)
      CMD_DIV_MIN: div_in = umin - lamx;
      CMD_DIV_MAX: div_in = umax + lamx;
      default:     div_in = umin;
    endcase
  end

  assign r_we = (cmd == CMD_WR_MIN) || (cmd == CMD_WR_MAX);

  tv1d_ram #(.WIDTH(SW), .DEPTH(MAX_LEN)) u_sram (
    .clk   (clk),
    .we    (cmd == CMD_LOAD),
    .waddr (fill),
    .wdata (s_tdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  tv1d_ram #(.WIDTH(SW), .DEPTH(MAX_LEN)) u_rram (
    .clk   (clk),
    .we    (r_we),
    .waddr (k0[AW-1:0]),
    .wdata (sat32(cmd == CMD_WR_MAX ? vmax : vmin)),
    .raddr (oidx),
    .rdata (r_rdata)
  );

  tv1d_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_in),
    .divisor  (len),
    .busy     (div_busy),
    .quot     (quot)
  );

  always_comb begin
    stat.fill_last  = fill == AW'(MAX_LEN - 1);
    stat.umin_neg   = umin < 0;
    stat.umax_pos   = umax > 0;
    stat.umin_lt_nl = umin < -lamx;
    stat.umax_gt_l  = umax > lamx;
    stat.umin_ge_l  = umin >= lamx;
    stat.umax_le_nl = umax <= -lamx;
    stat.k_eq_last  = k == nm1;
    stat.k_gt_last  = k > nm1;
    stat.k0_ge_km   = k0 >= km;
    stat.k0_ge_kp   = k0 >= kp;
    stat.k0_ge_k    = k0 >= k;
    stat.guard_hit  = guard >= GW'(GUARD_MAX);
    stat.div_busy   = div_busy;
    stat.o_last     = {1'b0, oidx} == nm1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lam  <= LAMBDA_RESET;
      fill <= '0;
    end else begin
      if (cfg_valid) begin
        lam <= cfg_data;
      end
      if (cmd == CMD_LOAD) begin
        if (s_tlast || stat.fill_last) begin
          n    <= CW'(fill) + 1'b1;
          fill <= '0;
        end else begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_INIT_A: begin
        k     <= '0;
        k0    <= '0;
        km    <= '0;
        kp    <= '0;
        guard <= '0;
        oidx  <= '0;
      end
      CMD_INIT_B: begin
        vmin <= rdx - lamx;
        vmax <= rdx + lamx;
        umin <= lamx;
        umax <= -lamx;
      end
      CMD_TOP: guard <= guard + 1'b1;
      CMD_B1: begin
        smp  <= rdx;
        umin <= umin + rdx - vmin;
      end
      CMD_B3: umax <= umax + smp - vmax;
      CMD_KINC: k <= kp1;
      CMD_WR_MIN, CMD_WR_MAX: k0 <= k0 + 1'b1;
      CMD_E1: begin
        k    <= k0;
        km   <= k0;
        vmin <= rdx;
        umin <= lamx;
        umax <= rdx + lamx - vmax;
      end
      CMD_E2: begin
        k    <= k0;
        kp   <= k0;
        vmax <= rdx;
        umax <= -lamx;
        umin <= rdx - lamx - vmin;
      end
      CMD_F1: begin
        k    <= k0;
        km   <= k0;
        kp   <= k0;
        vmin <= rdx;
        vmax <= rdx + two;
        umin <= lamx;
        umax <= -lamx;
      end
      CMD_F2: begin
        k    <= k0;
        km   <= k0;
        kp   <= k0;
        vmax <= rdx;
        vmin <= rdx - two;
        umin <= lamx;
        umax <= -lamx;
      end
      CMD_DIV_MIN: km <= k;
      CMD_DIV_MAX: kp <= k;
      CMD_APP_MIN: begin
        vmin <= vmin + quot;
        umin <= lamx;
      end
      CMD_APP_MAX: begin
        vmax <= vmax + quot;
        umax <= -lamx;
      end
      CMD_OLAT: begin
        m_tdata <= r_rdata;
        m_tlast <= stat.o_last;
      end
      CMD_ONEXT: oidx <= oidx + 1'b1;
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/tv1d_ctrl.sv
// ----------------------------------------------------------------------------
// tv1d_ctrl
// Controller: sequences loading, the denoising scan and the result readout.
// ----------------------------------------------------------------------------
module tv1d_ctrl import tv1d_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tlast,
  input  logic             m_tready,
  input  tv1d_stat_t       stat,
  output logic             s_tready,
  output logic             m_tvalid,
  output logic [CMD_W-1:0] cmd
);

  localparam logic [4:0] S_LOAD   = 5'd0;
  localparam logic [4:0] S_INIT_A = 5'd1;
  localparam logic [4:0] S_INIT_B = 5'd2;
  localparam logic [4:0] S_TOP    = 5'd3;
  localparam logic [4:0] S_WCHK   = 5'd4;
  localparam logic [4:0] S_END    = 5'd5;
  localparam logic [4:0] S_EW1    = 5'd6;
  localparam logic [4:0] S_ER1    = 5'd7;
  localparam logic [4:0] S_E1     = 5'd8;
  localparam logic [4:0] S_EW2    = 5'd9;
  localparam logic [4:0] S_ER2    = 5'd10;
  localparam logic [4:0] S_E2     = 5'd11;
  localparam logic [4:0] S_EDW    = 5'd12;
  localparam logic [4:0] S_EW3    = 5'd13;
  localparam logic [4:0] S_RK1    = 5'd14;
  localparam logic [4:0] S_B1     = 5'd15;
  localparam logic [4:0] S_B2     = 5'd16;
  localparam logic [4:0] S_B4     = 5'd17;
  localparam logic [4:0] S_CHKMIN = 5'd18;
  localparam logic [4:0] S_DMW    = 5'd19;
  localparam logic [4:0] S_CHKMAX = 5'd20;
  localparam logic [4:0] S_DXW    = 5'd21;
  localparam logic [4:0] S_FW1    = 5'd22;
  localparam logic [4:0] S_FR1    = 5'd23;
  localparam logic [4:0] S_F1     = 5'd24;
  localparam logic [4:0] S_FW2    = 5'd25;
  localparam logic [4:0] S_FR2    = 5'd26;
  localparam logic [4:0] S_F2     = 5'd27;
  localparam logic [4:0] S_ORD    = 5'd28;
  localparam logic [4:0] S_OLAT   = 5'd29;
  localparam logic [4:0] S_OSHOW  = 5'd30;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = CMD_NOP;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    case (state)
      S_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd = CMD_LOAD;
          if (s_tlast || stat.fill_last) begin
            state_next = S_INIT_A;
          end
        end
      end
      S_INIT_A: begin
        cmd        = CMD_INIT_A;
        state_next = S_INIT_B;
      end
      S_INIT_B: begin
        cmd        = CMD_INIT_B;
        state_next = S_TOP;
      end
      S_TOP: begin
        cmd        = CMD_TOP;
        state_next = stat.guard_hit ? S_ORD : S_WCHK;
      end
      S_WCHK: begin
        if (stat.k_eq_last) begin
          state_next = S_END;
        end else if (stat.k_gt_last) begin
          state_next = S_ORD;
        end else begin
          state_next = S_RK1;
        end
      end
      S_END: begin
        if (stat.umin_neg) begin
          state_next = S_EW1;
        end else if (stat.umax_pos) begin
          state_next = S_EW2;
        end else begin
          cmd        = CMD_DIV_END;
          state_next = S_EDW;
        end
      end
      S_EW1: begin
        cmd = CMD_WR_MIN;
        if (stat.k0_ge_km) begin
          state_next = S_ER1;
        end
      end
      S_ER1: begin
        cmd        = CMD_RD_K0;
        state_next = S_E1;
      end
      S_E1: begin
        cmd        = CMD_E1;
        state_next = S_WCHK;
      end
      S_EW2: begin
        cmd = CMD_WR_MAX;
        if (stat.k0_ge_kp) begin
          state_next = S_ER2;
        end
      end
      S_ER2: begin
        cmd        = CMD_RD_K0;
        state_next = S_E2;
      end
      S_E2: begin
        cmd        = CMD_E2;
        state_next = S_WCHK;
      end
      S_EDW: begin
        if (!stat.div_busy) begin
          cmd        = CMD_APP_MIN;
          state_next = S_EW3;
        end
      end
      S_EW3: begin
        cmd = CMD_WR_MIN;
        if (stat.k0_ge_k) begin
          state_next = S_ORD;
        end
      end
      S_RK1: begin
        cmd        = CMD_RD_K1;
        state_next = S_B1;
      end
      S_B1: begin
        cmd        = CMD_B1;
        state_next = S_B2;
      end
      S_B2: begin
        if (stat.umin_lt_nl) begin
          state_next = S_FW1;
        end else begin
          cmd        = CMD_B3;
          state_next = S_B4;
        end
      end
      S_B4: begin
        if (stat.umax_gt_l) begin
          state_next = S_FW2;
        end else begin
          cmd        = CMD_KINC;
          state_next = S_CHKMIN;
        end
      end
      S_CHKMIN: begin
        if (stat.umin_ge_l) begin
          cmd        = CMD_DIV_MIN;
          state_next = S_DMW;
        end else begin
          state_next = S_CHKMAX;
        end
      end
      S_DMW: begin
        if (!stat.div_busy) begin
          cmd        = CMD_APP_MIN;
          state_next = S_CHKMAX;
        end
      end
      S_CHKMAX: begin
        if (stat.umax_le_nl) begin
          cmd        = CMD_DIV_MAX;
          state_next = S_DXW;
        end else begin
          state_next = S_TOP;
        end
      end
      S_DXW: begin
        if (!stat.div_busy) begin
          cmd        = CMD_APP_MAX;
          state_next = S_TOP;
        end
      end
      S_FW1: begin
        cmd = CMD_WR_MIN;
        if (stat.k0_ge_km) begin
          state_next = S_FR1;
        end
      end
      S_FR1: begin
        cmd        = CMD_RD_K0;
        state_next = S_F1;
      end
      S_F1: begin
        cmd        = CMD_F1;
        state_next = S_TOP;
      end
      S_FW2: begin
        cmd = CMD_WR_MAX;
        if (stat.k0_ge_kp) begin
          state_next = S_FR2;
        end
      end
      S_FR2: begin
        cmd        = CMD_RD_K0;
        state_next = S_F2;
      end
      S_F2: begin
        cmd        = CMD_F2;
        state_next = S_TOP;
      end
      S_ORD: begin
        cmd        = CMD_ORD;
        state_next = S_OLAT;
      end
      S_OLAT: begin
        cmd        = CMD_OLAT;
        state_next = S_OSHOW;
      end
      S_OSHOW: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          cmd        = CMD_ONEXT;
          state_next = stat.o_last ? S_LOAD : S_ORD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

endmodule

// File: hw/rtl/tv1d_denoise_line_core.sv
// Operation: a line of n samples loads at one beat per cycle; each scan step may then
// divide by the segment length, at most twice, using the 40-step bit-serial divider,
// and the scan waits while the divider is busy.
// Readout reads, latches and shows each result, holding it until the sink takes it.
// Reset (rst, synchronous, active high) returns to loading, empties the line and sets
// lambda to 1.0; the sample and result stores are not cleared.
// ----------------------------------------------------------------------------
// tv1d_denoise_line_core
// Direct 1-D total-variation denoising of one line of Q16.16 samples.
// ----------------------------------------------------------------------------
module tv1d_denoise_line_core import tv1d_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [SW-1:0] s_tdata,   // [31:0] sample
  input  logic          s_tlast,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [SW-1:0] m_tdata,   // [31:0] denoised
  output logic          m_tlast,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [LW-1:0] cfg_data
);

  tv1d_stat_t       stat;
  logic [CMD_W-1:0] cmd;

  assign cfg_ready = 1'b1;

  tv1d_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .m_tready (m_tready),
    .stat     (stat),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  tv1d_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

// File: hw/rtl/tv1d_checker.sv
// ----------------------------------------------------------------------------
// tv1d_checker
// Port-level checks of the denoiser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tv1d_checker import tv1d_pkg::*; (
  input logic          clk,
  input logic          rst,
  input logic          s_tvalid,
  input logic          s_tready,
  input logic          s_tlast,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [SW-1:0] m_tdata,
  input logic          m_tlast
);

  // Loading and readout never overlap.
  `ASSERT_SAME(a_no_overlap, s_tready, !m_tvalid)
  // A closing input beat stops intake until the line is delivered.
  `ASSERT_NEXT(a_stop_after_last, s_tvalid && s_tready && s_tlast, !s_tready)
  // The final result beat ends the readout.
  `ASSERT_NEXT(a_out_ends, m_tvalid && m_tready && m_tlast, !m_tvalid)
  // A stalled result beat stays put.
  `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind tv1d_denoise_line_core tv1d_checker u_tv1d_checker (.*);
